### rtl/julia_escape_time_defines.svh
// ----------------------------------------------------------------------------
// Julia escape-time assertion macros
// Shared concurrent assertion forms for the escape-time block.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_DEFINES_SVH
`define JULIA_ESCAPE_TIME_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define JET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define JET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// Julia escape-time package
// Types, constants and register codes shared by the escape-time modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jet_pkg;

  localparam int unsigned PIX_W       = 12;
  localparam int unsigned IMAGE_DIM   = 4096;
  localparam int unsigned ITER_LIMIT  = 65535;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned FRAC_W      = 26;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned BOUND_W     = 31;
  localparam int unsigned REG_IDX_W   = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_RE       = 3'd0,
    REG_LOW_IM       = 3'd1,
    REG_STEP_RE      = 3'd2,
    REG_STEP_IM      = 3'd3,
    REG_C_RE         = 3'd4,
    REG_C_IM         = 3'd5,
    REG_MAX_ITER     = 3'd6,
    REG_ESCAPE_BOUND = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0]   low_re;
    logic signed [31:0]   low_im;
    logic signed [31:0]   step_re;
    logic signed [31:0]   step_im;
    logic signed [31:0]   c_re;
    logic signed [31:0]   c_im;
    logic [CNT_W-1:0]     max_iter;
    logic [BOUND_W-1:0]   escape_bound;
  } cfg_t;

  // Start point of one pixel, handed from the front end to the iterator.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } start_pt_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TEST,
    B_CHECK,
    B_UPDATE,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

### rtl/julia_escape_time.sv
// ----------------------------------------------------------------------------
// Julia escape-time iterator, top level
// Maps pixels to complex start points and counts iterations until escape.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   cfg       in         cfg_valid/cfg_ready   cfg_index (3 b), cfg_data (32 b)
//   in        in         in_valid/in_ready     pixel_x (12 b), pixel_y (12 b)
//   out       out        out_valid/out_ready   iter_count (16 b)
//
// The front end handles one pixel at a time: it accepts and wraps the
// coordinates, forms the coordinate products and then hands the start
// point to the queue, holding it there until the queue takes it.
// Each iteration runs as multiply, escape test and update, on one shared
// set of three 32x32 multipliers. A pixel is loaded before its first
// iteration and its count is retired after the last; at the limit it
// stops without a further multiply or test.
// Reset is synchronous; it empties the queue, idles both halves, drops
// out_valid and returns the registers to their reset values.
// A stalled output only blocks the iterator; the front end and the queue
// keep taking pixels until the queue is full.
//
// Each configuration transaction is taken in the cycle it is offered.
// Registers are expected to change only while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time #(
  parameter int unsigned Q_DEPTH = jet_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [jet_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [jet_pkg::PIX_W-1:0]        pixel_x,
  input  logic [jet_pkg::PIX_W-1:0]        pixel_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [jet_pkg::CNT_W-1:0]        iter_count
);

  jet_pkg::cfg_t      cfg;
  jet_pkg::start_pt_t push_data, pop_data;
  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_re       <= '0;
      cfg.low_im       <= '0;
      cfg.step_re      <= '0;
      cfg.step_im      <= '0;
      cfg.c_re         <= '0;
      cfg.c_im         <= '0;
      cfg.max_iter     <= jet_pkg::CNT_W'(255);
      cfg.escape_bound <= jet_pkg::BOUND_W'(134217728);
    end else if (cfg_valid && cfg_ready) begin
      case (jet_pkg::reg_idx_t'(cfg_index))
        jet_pkg::REG_LOW_RE:       cfg.low_re       <= cfg_data;
        jet_pkg::REG_LOW_IM:       cfg.low_im       <= cfg_data;
        jet_pkg::REG_STEP_RE:      cfg.step_re      <= cfg_data;
        jet_pkg::REG_STEP_IM:      cfg.step_im      <= cfg_data;
        jet_pkg::REG_C_RE:         cfg.c_re         <= cfg_data;
        jet_pkg::REG_C_IM:         cfg.c_im         <= cfg_data;
        jet_pkg::REG_MAX_ITER:     cfg.max_iter     <= cfg_data[jet_pkg::CNT_W-1:0];
        jet_pkg::REG_ESCAPE_BOUND: cfg.escape_bound <= cfg_data[jet_pkg::BOUND_W-1:0];
        default:                   cfg.c_im         <= cfg.c_im;
      endcase
    end
  end

  // The front end turns each pixel into a start point.
  jet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Start points wait here while the iterator is busy.
  jet_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The iterator owns the output register.
  jet_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iter_count (iter_count)
  );

endmodule

`default_nettype wire

### rtl/jet_front.sv
// ----------------------------------------------------------------------------
// Julia escape-time front end
// Accepts a pixel, wraps it to the image size and forms its start point.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_front (
  input  logic                         clk,
  input  logic                         rst,
  input  jet_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jet_pkg::PIX_W-1:0]    pixel_x,
  input  logic [jet_pkg::PIX_W-1:0]    pixel_y,
  output logic                         push_valid,
  input  logic                         push_ready,
  output jet_pkg::start_pt_t           push_data
);

  localparam int unsigned PW = jet_pkg::PIX_W;

  jet_pkg::front_state_t state, state_next;

  logic [PW-1:0] px, py;
  logic [31:0]   prod_re, prod_im;
  logic [31:0]   sum_im;
  logic          take, mul_en;

  always_comb begin
    state_next = state;
    case (state)
      jet_pkg::F_IDLE:   if (in_valid) state_next = jet_pkg::F_MUL;
      jet_pkg::F_MUL:    state_next = jet_pkg::F_PUSH;
      jet_pkg::F_PUSH:   if (push_ready) state_next = jet_pkg::F_IDLE;
      default:           state_next = jet_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    mul_en     = 1'b0;
    case (state)
      jet_pkg::F_IDLE:   in_ready   = 1'b1;
      jet_pkg::F_MUL:    mul_en     = 1'b1;
      jet_pkg::F_PUSH:   push_valid = 1'b1;
      default:           in_ready   = 1'b0;
    endcase
  end

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jet_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The image size is a power of two, so the wrap of each coordinate is a
  // plain mask taken as the pixel is accepted.
  always_ff @(posedge clk) begin
    if (take) begin
      px <= PW'(32'(pixel_x) % jet_pkg::IMAGE_DIM);
      py <= PW'(32'(pixel_y) % jet_pkg::IMAGE_DIM);
    end
    if (mul_en) begin
      prod_re <= 32'(32'(px) * cfg.step_re);
      prod_im <= 32'(32'(py) * cfg.step_im);
    end
  end

  // Both sums wrap modulo 2^32; the imaginary part is negated, so the
  // most negative value maps onto itself.
  assign sum_im       = cfg.low_im + prod_im;
  assign push_data.re = cfg.low_re + prod_re;
  assign push_data.im = 32'd0 - sum_im;

endmodule

`default_nettype wire

### rtl/jet_queue.sv
// ----------------------------------------------------------------------------
// Julia escape-time start-point queue
// Short first-in first-out buffer between the front end and the iterator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "julia_escape_time_defines.svh"

module jet_queue #(
  parameter int unsigned DEPTH = jet_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  jet_pkg::start_pt_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output jet_pkg::start_pt_t  pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jet_pkg::start_pt_t entries [DEPTH];

  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  `JET_ASSERT(a_q_count_bound, count <= CW'(DEPTH), "queue count above depth")
  `JET_ASSERT(a_q_count_track, 1'b1 |=> count == $past(count) + CW'($past(do_push)) - CW'($past(do_pop)), "queue count lost track")
  `JET_ASSERT(a_q_empty_ptrs, count == '0 |-> wr_ptr == rd_ptr, "empty queue with split pointers")

endmodule

`default_nettype wire

### rtl/jet_back.sv
// ----------------------------------------------------------------------------
// Julia escape-time iterator
// Runs z = z*z + c on one start point and registers the escape count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "julia_escape_time_defines.svh"

module jet_back (
  input  logic                         clk,
  input  logic                         rst,
  input  jet_pkg::cfg_t                cfg,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  jet_pkg::start_pt_t           pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [jet_pkg::CNT_W-1:0]    iter_count
);

  localparam int unsigned CW = jet_pkg::CNT_W;
  localparam int unsigned FW = jet_pkg::FRAC_W;
  localparam logic [CW-1:0] LIMIT_CAP = CW'(jet_pkg::ITER_LIMIT);

  jet_pkg::back_state_t state, state_next;

  logic signed [31:0] re, im;
  logic signed [63:0] rr, ii, ri;
  logic signed [63:0] diff;
  logic [63:0]        mag_sum;
  logic [63-FW:0]     mag;
  logic signed [38:0] re_part, im_part;
  logic signed [39:0] re_sum, im_sum;
  logic [CW-1:0]      iter, lim, lim_cfg;
  logic               escape, at_limit, out_free;
  logic               load_en, mul_en, chk_en, upd_en, res_en;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign lim_cfg  = (cfg.max_iter > LIMIT_CAP) ? LIMIT_CAP : cfg.max_iter;
  assign at_limit = (iter == lim);
  assign out_free = !out_valid || out_ready;

  // Squared magnitude of the current point, truncated to unsigned Q12.26.
  assign mag_sum = 64'(rr) + 64'(ii);
  assign mag     = mag_sum[63:FW];
  assign escape  = mag > {{(64 - FW - jet_pkg::BOUND_W){1'b0}}, cfg.escape_bound};

  // Arithmetic shifts round toward minus infinity.
  assign diff    = rr - ii;
  assign re_sum  = 40'(re_part) + 40'(cfg.c_re);
  assign im_sum  = 40'(im_part) + 40'(cfg.c_im);

  always_comb begin
    state_next = state;
    case (state)
      jet_pkg::B_IDLE:   if (pop_valid) state_next = jet_pkg::B_TEST;
      jet_pkg::B_TEST:   state_next = at_limit ? jet_pkg::B_DONE : jet_pkg::B_CHECK;
      jet_pkg::B_CHECK:  state_next = escape ? jet_pkg::B_DONE : jet_pkg::B_UPDATE;
      jet_pkg::B_UPDATE: state_next = jet_pkg::B_TEST;
      jet_pkg::B_DONE:   if (out_free) state_next = jet_pkg::B_IDLE;
      default:           state_next = jet_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    load_en   = 1'b0;
    mul_en    = 1'b0;
    chk_en    = 1'b0;
    upd_en    = 1'b0;
    res_en    = 1'b0;
    case (state)
      jet_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        load_en   = pop_valid;
      end
      jet_pkg::B_TEST:   mul_en = !at_limit;
      jet_pkg::B_CHECK:  chk_en = 1'b1;
      jet_pkg::B_UPDATE: upd_en = 1'b1;
      jet_pkg::B_DONE:   res_en = out_free;
      default:           pop_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jet_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      re   <= pop_data.re;
      im   <= pop_data.im;
      iter <= '0;
      lim  <= lim_cfg;
    end else if (upd_en) begin
      re   <= sat32(re_sum);
      im   <= sat32(im_sum);
      iter <= iter + 1'b1;
    end
    if (mul_en) begin
      rr <= re * re;
      ii <= im * im;
      ri <= re * im;
    end
    if (chk_en) begin
      re_part <= 39'($signed(diff[63:FW]));
      im_part <= ri[63:FW-1];
    end
    if (res_en) begin
      iter_count <= iter;
    end
  end

  `JET_ASSERT(a_b_iter_bound, state != jet_pkg::B_IDLE |-> iter <= lim, "iteration count past limit")
  `JET_ASSERT(a_b_check_below, state == jet_pkg::B_CHECK |-> iter < lim, "escape test at the limit")
  `JET_ASSERT(a_b_update_step, state == jet_pkg::B_UPDATE |=> state == jet_pkg::B_TEST && iter == $past(iter) + 1'b1, "update did not advance")

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Julia escape-time iterator testbench
// Drives pixel coordinates and register writes into julia_escape_time. Every
// iteration count that comes back is compared with a bit-exact Q6.26 predictor
// kept in this file. The run opens with a table of directed rows and goes on
// to random phases. Each phase rewrites the registers and then streams random
// pixels. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
  import jet_pkg::*;

  // Run shape. The cycle limit is several times the slowest correct run:
  // one pixel at 65535 iterations, plus ~770 pixels at up to 255
  // iterations each, plus every stall and gap.
  localparam int unsigned RUN_LIMIT        = 4_000_000;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned PIXELS_PER_PHASE = 75;
  localparam int unsigned HOLD_CYCLES      = 600;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned TAIL_CYCLES      = 40;
  localparam int unsigned MAX_REPORTS      = 50;
  localparam longint      S32_MAX          = 64'sd2147483647;
  localparam longint      S32_MIN          = -64'sd2147483648;

  // One row of the directed table. A row is either a register write or a
  // pixel. A pixel row may carry a count that is obvious by inspection. Rows
  // without that count are checked against the predictor.
  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    reg_idx_t         reg_sel;
    logic [31:0]      data;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             typed;
    logic [CNT_W-1:0] count;
  } plan_row_t;

  // The rows in order:
  //   - The reset state: z and c are zero, so z never moves and every pixel
  //     runs to the limit of 255.
  //   - A zero limit returns 0 without any test.
  //   - A limit of 1, with start points at -32.0 and just under +32.0.
  //   - The negation of the most negative value: low_im = -32.0 gives an
  //     imaginary start that wraps to -32.0 again.
  //   - A classic Julia window.
  //   - Real-part saturation: start at 5.6 with c_re at the positive rail,
  //     then start at -5.6i with c_re at the negative rail.
  //   - Bound zero with c at both negative rails.
  //   - The largest limit on a point that never escapes.
  localparam int unsigned PLAN_ROWS = 46;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd0,    1'b1, 16'd255},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd4095, 12'd4095, 1'b1, 16'd255},
    '{ROW_CFG, REG_MAX_ITER,     32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd123,  12'd456,  1'b1, 16'd0},
    '{ROW_CFG, REG_MAX_ITER,     32'h0000_0001, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_RE,       32'h8000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd0,    1'b1, 16'd0},
    '{ROW_CFG, REG_LOW_RE,       32'h7FFF_FFFF, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd4095, 12'd0,    1'b1, 16'd0},
    '{ROW_CFG, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_IM,       32'h8000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd4095, 1'b1, 16'd0},
    '{ROW_CFG, REG_LOW_RE,       32'hFA00_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_IM,       32'hFA00_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_STEP_RE,      32'h0000_C000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_STEP_IM,      32'h0000_C000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_C_RE,         32'hFCCC_CCCD, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_C_IM,         32'h009F_BE76, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_MAX_ITER,     32'h0000_00FF, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd4095, 12'd4095, 1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd2048, 12'd2048, 1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd1000, 12'd3000, 1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd3071, 12'd1024, 1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd1707, 12'd2389, 1'b0, 16'd0},
    '{ROW_CFG, REG_ESCAPE_BOUND, 32'h7FFF_FFFF, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_C_RE,         32'h7FFF_FFFF, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_STEP_RE,      32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_STEP_IM,      32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_RE,       32'h1666_6666, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_IM,       32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_MAX_ITER,     32'h0000_0010, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd7,    12'd9,    1'b0, 16'd0},
    '{ROW_CFG, REG_C_RE,         32'h8000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_IM,       32'h1666_6666, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd100,  12'd200,  1'b0, 16'd0},
    '{ROW_CFG, REG_LOW_IM,       32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_C_IM,         32'h8000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_ESCAPE_BOUND, 32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd1,    12'd1,    1'b1, 16'd1},
    '{ROW_CFG, REG_C_RE,         32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_C_IM,         32'h0000_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_ESCAPE_BOUND, 32'h0800_0000, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_CFG, REG_MAX_ITER,     32'h0000_FFFF, 12'd0,    12'd0,    1'b0, 16'd0},
    '{ROW_PIX, REG_LOW_RE,       32'h0000_0000, 12'd0,    12'd0,    1'b1, 16'd65535}
  };

  // One expected iteration count, kept with its pixel for the error message.
  typedef struct {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [CNT_W-1:0] count;
  } pixel_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel_x   = '0;
  logic [PIX_W-1:0]     pixel_y   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CNT_W-1:0]     iter_count;

  // The predictor's copy of the register file. It is updated at the edge
  // where each configuration transaction is accepted.
  cfg_t          model_cfg;
  pixel_result_t count_q [$];

  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned stall_left  = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_taken  = 1'b0;

  julia_escape_time DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iter_count (iter_count)
  );

  always #1 clk = ~clk;

  // Watchdog. A lost result or a hung handshake ends up here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > S32_MAX)
      return 32'sh7FFF_FFFF;
    if (v < S32_MIN)
      return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Maps the pixel to its start point and iterates z = z*z + c. Products are
  // exact 64-bit values. The norm is the unsigned sum of the squares shifted
  // right by 26 bits. The update shifts are arithmetic, so they round toward
  // minus infinity. Each new part is clamped to the 32-bit signed range.
  function automatic logic [CNT_W-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                     input logic [PIX_W-1:0] py);
    logic [31:0]      col, row, re_bits, im_bits;
    longint           re, im, rr, ii, ri;
    logic [63:0]      norm;
    int unsigned      lim, n;
    logic [CNT_W-1:0] steps;
    col = 32'(px) % IMAGE_DIM;
    row = 32'(py) % IMAGE_DIM;
    lim = model_cfg.max_iter;
    if (lim > ITER_LIMIT)
      lim = ITER_LIMIT;
    // The start point wraps modulo 2^32, and so does the negation of the
    // imaginary part.
    re_bits = model_cfg.low_re + col * model_cfg.step_re;
    im_bits = 32'd0 - (model_cfg.low_im + row * model_cfg.step_im);
    re = $signed(re_bits);
    im = $signed(im_bits);
    steps = CNT_W'(lim);
    for (n = 0; n < lim; n++) begin
      rr = re * re;
      ii = im * im;
      ri = re * im;
      norm = ($unsigned(rr) + $unsigned(ii)) >> FRAC_W;
      if (norm > 64'(model_cfg.escape_bound)) begin
        steps = CNT_W'(n);
        break;
      end
      re = clamp32(((rr - ii) >>> FRAC_W) + $signed(model_cfg.c_re));
      im = clamp32((ri >>> (FRAC_W - 1)) + $signed(model_cfg.c_im));
    end
    return steps;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic logic [31:0] to_q(input real v);
    return 32'($rtoi(v * 67108864.0));
  endfunction

  function automatic real rand_real(input real lo, input real hi);
    return lo + (hi - lo) * real'($urandom_range(0, 1_000_000)) / 1.0e6;
  endfunction

  // The length of an idle stretch. Most stretches are empty or short, and a
  // few are long. The sender and the receiver both use it.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic log_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("ERROR cycle %0d: %s", cycle_cnt, what);
  endtask

  // Offers one register write and waits for its transaction. The predictor
  // copy changes at the same edge as the block's register does.
  task automatic write_reg(input reg_idx_t sel, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      REG_LOW_RE:       model_cfg.low_re       = value;
      REG_LOW_IM:       model_cfg.low_im       = value;
      REG_STEP_RE:      model_cfg.step_re      = value;
      REG_STEP_IM:      model_cfg.step_im      = value;
      REG_C_RE:         model_cfg.c_re         = value;
      REG_C_IM:         model_cfg.c_im         = value;
      REG_MAX_ITER:     model_cfg.max_iter     = value[CNT_W-1:0];
      REG_ESCAPE_BOUND: model_cfg.escape_bound = value[BOUND_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one pixel, with an optional random gap first. The task returns
  // at the edge where the pixel is accepted and leaves in_valid high. A
  // following pixel with no gap therefore keeps in_valid high with no break
  // in between. The count is the typed-in value where one is given, and
  // otherwise the predictor's result.
  task automatic offer_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                             input logic typed, input logic [CNT_W-1:0] count);
    int unsigned   gap;
    pixel_result_t entry;
    gap = calm ? 0 : gap_len();
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    do @(posedge clk); while (!in_ready);
    entry.x     = x;
    entry.y     = y;
    entry.count = typed ? count : escape_count(x, y);
    count_q.insert(count_q.size(), entry);
  endtask

  // Drops both valids and waits until every expected count has arrived.
  // Each pixel gives exactly one result, so an empty queue means that the
  // block is idle. The extra cycles are a margin before the registers
  // change.
  task automatic drain_and_settle(input int unsigned extra);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (count_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Result side: checks every output transaction and drives out_ready.
  // -------------------------------------------------------------------------

  // Outputs are sampled at the edge, before the block's registers update.
  // When the stimulus raises the hold request, this process stalls the
  // output, counting the stall down from HOLD_CYCLES. The sender keeps
  // offering pixels meanwhile, so the internal queue fills and in_ready drops.
  always @(posedge clk) begin : result_side
    pixel_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (count_q.size() == 0) begin
          log_mismatch($sformatf("result %0d with no pixel outstanding", iter_count));
        end else begin
          want = count_q.pop_front();
          if (iter_count !== want.count)
            log_mismatch($sformatf("pixel (%0d,%0d): iter_count %0d, predicted %0d",
                                   want.x, want.y, iter_count, want.count));
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus: the directed table, then random phases.
  // -------------------------------------------------------------------------

  initial begin : stimulus
    logic [31:0] vals [8];
    real         span, mid_re, mid_im, seed_re, seed_im;
    bit          noisy;
    int unsigned ph, r;

    model_cfg              = '0;
    model_cfg.max_iter     = 16'd255;
    model_cfg.escape_bound = 31'd134217728;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A register row that follows pixels waits for the block to drain, so
    // that no pixel is in flight when the register changes.
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        if (i > 0 && PLAN[i-1].kind == ROW_PIX)
          drain_and_settle(SETTLE_CYCLES);
        write_reg(PLAN[i].reg_sel, PLAN[i].data);
      end else begin
        offer_pixel(PLAN[i].x, PLAN[i].y, PLAN[i].typed, PLAN[i].count);
      end
    end

    // Random phases. Most phases set up a proper Julia view: a window around
    // the origin, a well-known c with a small offset, and a moderate limit.
    // Many pixels then iterate for a long time. Some phases fill every
    // register with random bits. Bits above the field width are dropped.
    // Some phases are calm, with no gaps on either side. Phase 1 carries the
    // long output hold.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_and_settle(SETTLE_CYCLES);
      calm  = (ph != 1) && ($urandom_range(0, 3) == 0);
      noisy = (ph != 1) && ($urandom_range(0, 4) == 0);
      if (noisy) begin
        foreach (vals[k])
          vals[k] = $urandom();
        // Keep the limit small, because a random view may never escape.
        vals[REG_MAX_ITER][CNT_W-1:0] = CNT_W'($urandom_range(1, 64));
      end else begin
        span   = rand_real(0.02, 4.0);
        mid_re = rand_real(-0.6, 0.6);
        mid_im = rand_real(-0.6, 0.6);
        vals[REG_LOW_RE]  = to_q(mid_re - span / 2.0);
        vals[REG_STEP_RE] = to_q(span / 4096.0);
        // Rows run up or down the imaginary axis, so both signs of the
        // step are used.
        if ($urandom_range(0, 1) == 1) begin
          vals[REG_LOW_IM]  = to_q(mid_im + span / 2.0);
          vals[REG_STEP_IM] = to_q(-span / 4096.0);
        end else begin
          vals[REG_LOW_IM]  = to_q(mid_im - span / 2.0);
          vals[REG_STEP_IM] = to_q(span / 4096.0);
        end
        case ($urandom_range(0, 5))
          0: begin seed_re = -0.8;     seed_im = 0.156;   end
          1: begin seed_re = -0.4;     seed_im = 0.6;     end
          2: begin seed_re = 0.285;    seed_im = 0.01;    end
          3: begin seed_re = -0.70176; seed_im = -0.3842; end
          4: begin seed_re = 0.355;    seed_im = 0.355;   end
          default: begin seed_re = -0.835; seed_im = -0.2321; end
        endcase
        vals[REG_C_RE]     = to_q(seed_re + rand_real(-0.02, 0.02));
        vals[REG_C_IM]     = to_q(seed_im + rand_real(-0.02, 0.02));
        vals[REG_MAX_ITER] = $urandom_range(8, 255);
        case ($urandom_range(0, 2))
          0:       vals[REG_ESCAPE_BOUND] = to_q(2.0);
          1:       vals[REG_ESCAPE_BOUND] = to_q(4.0);
          default: vals[REG_ESCAPE_BOUND] = to_q(rand_real(0.0, 31.9));
        endcase
      end
      for (r = 0; r < 8; r++)
        write_reg(reg_idx_t'(r), vals[r]);
      if (ph == 1)
        hold_req = 1'b1;
      repeat (PIXELS_PER_PHASE)
        offer_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)),
                    1'b0, '0);
    end

    // Wait for the last count, then a short tail in which any extra result
    // shows up as a failure.
    drain_and_settle(TAIL_CYCLES);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/jet_pkg.sv
rtl/jet_front.sv
rtl/jet_queue.sv
rtl/jet_back.sv
rtl/julia_escape_time.sv
tb/tb.sv
